@@ sv/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared types, codes, character constants and lexer helper functions.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 24;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_TILDE      = 8'h7E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_IDENT,
    PH_NUMBER,
    PH_PLUS,
    PH_MINUS,
    PH_DOLLAR,
    PH_LINE_CMT,
    PH_BLOCK,
    PH_BLOCK_TILDE,
    PH_ERROR
  } phase_t;

  typedef enum logic [4:0] {
    TK_MINT    = 5'd0,
    TK_BAR     = 5'd1,
    TK_EXIT    = 5'd2,
    TK_IDENT   = 5'd3,
    TK_INTEGER = 5'd4,
    TK_DEC     = 5'd5,
    TK_MINUS   = 5'd6,
    TK_INC     = 5'd7,
    TK_PLUS    = 5'd8,
    TK_SEMI    = 5'd9,
    TK_ASSIGN  = 5'd10,
    TK_STAR    = 5'd11,
    TK_SLASH   = 5'd12,
    TK_PERCENT = 5'd13,
    TK_CARET   = 5'd14,
    TK_LPAREN  = 5'd15,
    TK_RPAREN  = 5'd16,
    TK_LBRACE  = 5'd17,
    TK_RBRACE  = 5'd18,
    TK_EOF     = 5'd19,
    TK_ERROR   = 5'd20
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNEXPECTED = 2'd1,
    ERR_UNCLOSED   = 2'd2
  } err_kind_t;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_END  = 1'b1
  } mode_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [1:0]  error_kind;
    logic [7:0]  bad_char;
    logic        last_of_run;
  } out_item_t;

  // One queue entry carries every result of one request: one or two tokens.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } qwrite_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qread_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDERSCORE});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c inside {CH_SEMI, 8'h3D, 8'h2A, 8'h2F, 8'h25, 8'h5E, 8'h28, 8'h29,
                      8'h7B, 8'h7D});
  endfunction

  function automatic tok_kind_t punct_kind(input logic [7:0] c);
    tok_kind_t k;
    case (c)
      CH_SEMI: k = TK_SEMI;
      8'h3D:   k = TK_ASSIGN;
      8'h2A:   k = TK_STAR;
      8'h2F:   k = TK_SLASH;
      8'h25:   k = TK_PERCENT;
      8'h5E:   k = TK_CARET;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

  // Bit k is set when keyword k (0 mint, 1 bar, 2 exit) does not have c at idx.
  function automatic logic [2:0] kw_miss(input logic [31:0] idx, input logic [7:0] c);
    logic [2:0] m;
    case (idx)
      32'd0:   m = {c != "e", c != "b", c != "m"};
      32'd1:   m = {c != "x", c != "a", c != "i"};
      32'd2:   m = {c != "i", c != "r", c != "n"};
      32'd3:   m = {c != "t", 1'b1, c != "t"};
      default: m = 3'b111;
    endcase
    return m;
  endfunction

  function automatic tok_kind_t ident_kind(input logic [2:0] kw, input logic [31:0] len);
    tok_kind_t k;
    if (kw[0] && len == 32'd4) begin
      k = TK_MINT;
    end else if (kw[1] && len == 32'd3) begin
      k = TK_BAR;
    end else if (kw[2] && len == 32'd4) begin
      k = TK_EXIT;
    end else begin
      k = TK_IDENT;
    end
    return k;
  endfunction

  function automatic logic [15:0] clamp16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [23:0] clamp24(input logic [31:0] v);
    return (v > 32'h00FF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

  function automatic out_item_t make_item(input logic [4:0] kind, input logic [31:0] line,
                                          input logic [31:0] col, input logic [31:0] off,
                                          input logic [31:0] len, input logic [1:0] ek,
                                          input logic [7:0] bc);
    out_item_t r;
    r.token_kind   = kind;
    r.start_line   = clamp16(line);
    r.start_column = clamp16(col);
    r.start_offset = clamp24(off);
    r.token_length = clamp16(len);
    r.error_kind   = ek;
    r.bad_char     = bc;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

@@ sv/stt_front.sv @@
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts source bytes, runs the lexer phase machine and position counters,
// and writes the one or two tokens that a request produces into the queue.
// ----------------------------------------------------------------------------
module stt_front #(
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  stt_pkg::in_item_t byte_item,
  input  logic              full,
  output stt_pkg::qwrite_t  wr
);

  stt_pkg::phase_t phase, phase_next;
  logic [2:0] kw_match, kw_match_next;
  logic [LENGTH_BITS-1:0] pend_len, pend_len_next, plen_inc;
  logic [LINE_BITS-1:0]   pend_line, pend_line_next, pend_col, pend_col_next;
  logic [OFFSET_BITS-1:0] pend_off, pend_off_next;
  logic [LINE_BITS-1:0]   cur_line, cur_line_next, cur_col, cur_col_next;
  logic [OFFSET_BITS-1:0] cur_off, cur_off_next;

  logic       accept, is_end, start, alnum;
  logic [7:0] c;
  logic       pe_emit, sb_emit;
  stt_pkg::out_item_t pe_res, sb_res, eof_res;

  assign byte_stall = full;
  assign accept     = byte_valid && !full;
  assign is_end     = (byte_item.mode == stt_pkg::MODE_END);
  assign c          = byte_item.byte_value;
  assign alnum      = stt_pkg::is_alpha(c) || stt_pkg::is_digit(c);
  assign plen_inc   = (&pend_len) ? pend_len : pend_len + LENGTH_BITS'(1);

  // A byte that does not continue a name, number or sign is lexed afresh.
  always_comb begin
    start = 1'b0;
    if (!is_end) begin
      case (phase)
        stt_pkg::PH_IDLE:   start = 1'b1;
        stt_pkg::PH_IDENT:  start = !alnum;
        stt_pkg::PH_NUMBER: start = !stt_pkg::is_digit(c);
        stt_pkg::PH_PLUS:   start = (c != stt_pkg::CH_PLUS);
        stt_pkg::PH_MINUS:  start = (c != stt_pkg::CH_MINUS);
        default:            start = 1'b0;
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_next     = phase;
    kw_match_next  = kw_match;
    pend_len_next  = pend_len;
    pend_line_next = pend_line;
    pend_col_next  = pend_col;
    pend_off_next  = pend_off;
    cur_off_next   = (&cur_off) ? cur_off : cur_off + OFFSET_BITS'(1);
    if (c == stt_pkg::CH_NEWLINE) begin
      cur_line_next = (&cur_line) ? cur_line : cur_line + LINE_BITS'(1);
      cur_col_next  = '0;
    end else begin
      cur_line_next = cur_line;
      cur_col_next  = (&cur_col) ? cur_col : cur_col + LINE_BITS'(1);
    end

    case (phase)
      stt_pkg::PH_IDENT: begin
        if (alnum) begin
          kw_match_next = kw_match & ~stt_pkg::kw_miss(32'(pend_len), c);
          pend_len_next = plen_inc;
        end
      end
      stt_pkg::PH_NUMBER: begin
        if (stt_pkg::is_digit(c)) pend_len_next = plen_inc;
      end
      stt_pkg::PH_PLUS: begin
        if (c == stt_pkg::CH_PLUS) phase_next = stt_pkg::PH_IDLE;
      end
      stt_pkg::PH_MINUS: begin
        if (c == stt_pkg::CH_MINUS) phase_next = stt_pkg::PH_IDLE;
      end
      stt_pkg::PH_DOLLAR: begin
        if (c == stt_pkg::CH_DOLLAR) begin
          pend_len_next = plen_inc;
          phase_next    = stt_pkg::PH_LINE_CMT;
        end else if (c == stt_pkg::CH_TILDE) begin
          pend_len_next = plen_inc;
          phase_next    = stt_pkg::PH_BLOCK;
        end else begin
          phase_next = stt_pkg::PH_ERROR;
        end
      end
      stt_pkg::PH_LINE_CMT: begin
        if (c == stt_pkg::CH_NEWLINE) phase_next = stt_pkg::PH_IDLE;
      end
      stt_pkg::PH_BLOCK: begin
        pend_len_next = plen_inc;
        if (c == stt_pkg::CH_TILDE) phase_next = stt_pkg::PH_BLOCK_TILDE;
      end
      stt_pkg::PH_BLOCK_TILDE: begin
        pend_len_next = plen_inc;
        if (c == stt_pkg::CH_DOLLAR) begin
          phase_next = stt_pkg::PH_IDLE;
        end else if (c != stt_pkg::CH_TILDE) begin
          phase_next = stt_pkg::PH_BLOCK;
        end
      end
      default: begin
      end
    endcase

    if (start) begin
      phase_next = stt_pkg::PH_IDLE;
      if (alnum || c == stt_pkg::CH_PLUS || c == stt_pkg::CH_MINUS ||
          c == stt_pkg::CH_DOLLAR) begin
        pend_line_next = cur_line;
        pend_col_next  = cur_col;
        pend_off_next  = cur_off;
        pend_len_next  = LENGTH_BITS'(1);
      end
      if (stt_pkg::is_alpha(c)) begin
        phase_next    = stt_pkg::PH_IDENT;
        kw_match_next = ~stt_pkg::kw_miss(32'd0, c);
      end else if (stt_pkg::is_digit(c)) begin
        phase_next = stt_pkg::PH_NUMBER;
      end else if (c == stt_pkg::CH_PLUS) begin
        phase_next = stt_pkg::PH_PLUS;
      end else if (c == stt_pkg::CH_MINUS) begin
        phase_next = stt_pkg::PH_MINUS;
      end else if (c == stt_pkg::CH_DOLLAR) begin
        phase_next = stt_pkg::PH_DOLLAR;
      end else if (!stt_pkg::is_space(c) && !stt_pkg::is_punct(c)) begin
        phase_next = stt_pkg::PH_ERROR;
      end
    end

    // End of source returns every counter to its reset value.
    if (is_end) begin
      phase_next     = stt_pkg::PH_IDLE;
      kw_match_next  = 3'b111;
      pend_len_next  = '0;
      pend_line_next = '0;
      pend_col_next  = '0;
      pend_off_next  = '0;
      cur_line_next  = '0;
      cur_col_next   = '0;
      cur_off_next   = '0;
    end
  end

  // Outputs
  always_comb begin
    pe_emit = 1'b0;
    pe_res  = stt_pkg::make_item(stt_pkg::TK_ERROR, 32'(pend_line), 32'(pend_col),
                                 32'(pend_off), 32'd1, stt_pkg::ERR_UNEXPECTED,
                                 stt_pkg::CH_DOLLAR);
    sb_emit = 1'b0;
    sb_res  = stt_pkg::make_item(stt_pkg::TK_ERROR, 32'(cur_line), 32'(cur_col),
                                 32'(cur_off), 32'd1, stt_pkg::ERR_UNEXPECTED, c);
    eof_res = stt_pkg::make_item(stt_pkg::TK_EOF, 32'(cur_line), 32'(cur_col),
                                 32'(cur_off), 32'd0, stt_pkg::ERR_NONE, 8'd0);

    case (phase)
      stt_pkg::PH_IDENT: begin
        pe_emit = is_end || !alnum;
        pe_res  = stt_pkg::make_item(stt_pkg::ident_kind(kw_match, 32'(pend_len)),
                                     32'(pend_line), 32'(pend_col), 32'(pend_off),
                                     32'(pend_len), stt_pkg::ERR_NONE, 8'd0);
      end
      stt_pkg::PH_NUMBER: begin
        pe_emit = is_end || !stt_pkg::is_digit(c);
        pe_res  = stt_pkg::make_item(stt_pkg::TK_INTEGER, 32'(pend_line), 32'(pend_col),
                                     32'(pend_off), 32'(pend_len), stt_pkg::ERR_NONE, 8'd0);
      end
      stt_pkg::PH_PLUS: begin
        pe_emit = 1'b1;
        if (!is_end && c == stt_pkg::CH_PLUS) begin
          pe_res = stt_pkg::make_item(stt_pkg::TK_INC, 32'(pend_line), 32'(pend_col),
                                      32'(pend_off), 32'(plen_inc), stt_pkg::ERR_NONE, 8'd0);
        end else begin
          pe_res = stt_pkg::make_item(stt_pkg::TK_PLUS, 32'(pend_line), 32'(pend_col),
                                      32'(pend_off), 32'(pend_len), stt_pkg::ERR_NONE, 8'd0);
        end
      end
      stt_pkg::PH_MINUS: begin
        pe_emit = 1'b1;
        if (!is_end && c == stt_pkg::CH_MINUS) begin
          pe_res = stt_pkg::make_item(stt_pkg::TK_DEC, 32'(pend_line), 32'(pend_col),
                                      32'(pend_off), 32'(plen_inc), stt_pkg::ERR_NONE, 8'd0);
        end else begin
          pe_res = stt_pkg::make_item(stt_pkg::TK_MINUS, 32'(pend_line), 32'(pend_col),
                                      32'(pend_off), 32'(pend_len), stt_pkg::ERR_NONE, 8'd0);
        end
      end
      stt_pkg::PH_DOLLAR: begin
        // A lone dollar reports itself; the byte after it is dropped.
        pe_emit = is_end || (c != stt_pkg::CH_DOLLAR && c != stt_pkg::CH_TILDE);
      end
      stt_pkg::PH_BLOCK, stt_pkg::PH_BLOCK_TILDE: begin
        pe_emit = is_end;
        pe_res  = stt_pkg::make_item(stt_pkg::TK_ERROR, 32'(pend_line), 32'(pend_col),
                                     32'(pend_off), 32'(pend_len), stt_pkg::ERR_UNCLOSED,
                                     8'd0);
      end
      default: begin
      end
    endcase

    if (start) begin
      if (stt_pkg::is_punct(c)) begin
        sb_emit = 1'b1;
        sb_res  = stt_pkg::make_item(stt_pkg::punct_kind(c), 32'(cur_line), 32'(cur_col),
                                     32'(cur_off), 32'd1, stt_pkg::ERR_NONE, 8'd0);
      end else if (!alnum && !stt_pkg::is_space(c) && c != stt_pkg::CH_PLUS &&
                   c != stt_pkg::CH_MINUS && c != stt_pkg::CH_DOLLAR) begin
        sb_emit = 1'b1;
      end
    end

    // End of source always closes with end-of-file.
    if (is_end) begin
      sb_emit = 1'b1;
      sb_res  = eof_res;
    end

    wr.push = accept && (pe_emit || sb_emit);
    wr.entry.two    = pe_emit && sb_emit;
    wr.entry.first  = pe_emit ? pe_res : sb_res;
    wr.entry.second = sb_res;
    if (pe_emit && sb_emit) begin
      wr.entry.second.last_of_run = 1'b1;
    end else begin
      wr.entry.first.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= stt_pkg::PH_IDLE;
      kw_match  <= 3'b111;
      pend_len  <= '0;
      pend_line <= '0;
      pend_col  <= '0;
      pend_off  <= '0;
      cur_line  <= '0;
      cur_col   <= '0;
      cur_off   <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      kw_match  <= kw_match_next;
      pend_len  <= pend_len_next;
      pend_line <= pend_line_next;
      pend_col  <= pend_col_next;
      pend_off  <= pend_off_next;
      cur_line  <= cur_line_next;
      cur_col   <= cur_col_next;
      cur_off   <= cur_off_next;
    end
  end

endmodule

@@ sv/stt_queue.sv @@
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Short circular buffer of result entries between the front and back ends.
// ----------------------------------------------------------------------------
module stt_queue #(
  parameter int DEPTH = stt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  stt_pkg::qwrite_t wr,
  input  logic             pop,
  output logic             full,
  output stt_pkg::qread_t  rd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  stt_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count, count_next;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd.valid = (count != '0);
  assign rd.entry = slots[rptr];

  always_comb begin
    case ({wr.push, pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.push) slots[wptr] <= wr.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (wr.push) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      if (pop) rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr.push)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> rd.valid)
    else $error("queue read while empty");

endmodule

@@ sv/stt_back.sv @@
// ----------------------------------------------------------------------------
// Tokenizer back end
// Unpacks queue entries into single tokens and holds them in the output
// register until the receiver takes them.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic               clk,
  input  logic               rst,
  input  stt_pkg::qread_t    rd,
  output logic               pop,
  output logic               token_valid,
  input  logic               token_stall,
  output stt_pkg::out_item_t token_item
);

  logic sel;
  logic load, take;

  assign load = !token_valid || !token_stall;
  assign take = load && rd.valid;
  assign pop  = take && (sel || !rd.entry.two);

  always_ff @(posedge clk) begin
    if (take) token_item <= sel ? rd.entry.second : rd.entry.first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      sel         <= 1'b0;
    end else begin
      if (load) token_valid <= rd.valid;
      if (take) sel <= !pop;
    end
  end

  a_sel_needs_pair: assert property (@(posedge clk) disable iff (rst)
    sel |-> (rd.valid && rd.entry.two))
    else $error("second token selected without a two-token entry");

  a_pair_advances: assert property (@(posedge clk) disable iff (rst)
    (take && !sel && rd.entry.two) |=> sel)
    else $error("second token of an entry skipped");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    (take && !pop) |=> (token_valid && !token_item.last_of_run))
    else $error("first of two tokens marked last of run");

endmodule

@@ sv/source_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexer: source bytes in, tokens with kind, position and length out.
// ----------------------------------------------------------------------------
// Source bytes enter on the byte channel (byte_valid, byte_stall, byte_item);
// an item with mode set marks end of source. Tokens leave on the token channel
// (token_valid, token_stall, token_item), and last_of_run marks the final
// token that a request causes.
// One request is taken every cycle while byte_stall is low. The front end
// updates the lexer phase and position counters in the cycle of acceptance
// and writes that request's one or two tokens into a four-entry queue; the
// back end moves one token per cycle into the output register while the
// receiver does not stall. The edge that accepts a request writes the queue,
// and the back end then loads its tokens from the queue into the output
// register. A request that yields two tokens uses the single output register
// port once per token, so bytes are taken one per cycle while tokens keep up.
// When the receiver stalls, the output register holds its token, the queue
// fills, and byte_stall rises once all four entries are occupied.
// Reset clears the phase, counters and queue; no tokens are pending after it.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = stt_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  stt_pkg::in_item_t  byte_item,
  output logic               token_valid,
  input  logic               token_stall,
  output stt_pkg::out_item_t token_item
);

  stt_pkg::qwrite_t wr;
  stt_pkg::qread_t  rd;
  logic             full;
  logic             pop;

  stt_front #(
    .LINE_BITS  (LINE_BITS),
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item (byte_item),
    .full      (full),
    .wr        (wr)
  );

  stt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .pop (pop),
    .full(full),
    .rd  (rd)
  );

  stt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rd         (rd),
    .pop        (pop),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_item (token_item)
  );

endmodule
